>>> hw/rtl/plateau_peak_valley_marker_macros.svh
// assertion helpers for the plateau peak/valley marker
`ifndef PLATEAU_PEAK_VALLEY_MARKER_MACROS_SVH
`define PLATEAU_PEAK_VALLEY_MARKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PVM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PVM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PVM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/pvm_pkg.sv
package pvm_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int COUNT_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      LABEL_NONE,
      LABEL_PEAK,
      LABEL_VALLEY
   } label_type;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_RISE,
      DIR_FALL
   } dir_type;

   typedef struct packed {
      label_type   label;
      logic [15:0] run_length;
      logic        length_saturated;
      logic        last_of_row;
   } result_type;

   // up to two results per accepted sample, slot 0 filled first
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } wr_type;

endpackage

>>> hw/rtl/plateau_peak_valley_marker.sv
// plateau peak/valley marker
// input queue side: req_sample and req_row_end, one beat when push is high and
//   full is low; req_row_end marks the last sample of a row
// result queue side: the oldest result sits on rsp_* while empty is low and
//   leaves on a beat with pop high
// each closed run of equal samples gives one result: its length, a peak, valley or
//   none label, a saturation flag and a last-of-row flag
// a result caused by a sample is visible in the cycle after its beat
// throughput: one sample per cycle while full is low; a sample may give two results
//   (change of value on the row end), and the result queue drains one per cycle
// full rises when fewer than two queue slots are free, so a stalled receiver
//   backs up into the input and nothing is dropped
// reset (synchronous) empties the result queue and forgets any open run
`include "plateau_peak_valley_marker_macros.svh"

module plateau_peak_valley_marker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_sample,
   input  logic        req_row_end,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_label,
   output logic [15:0] rsp_run_length,
   output logic        rsp_length_saturated,
   output logic        rsp_last_of_row
);
   import pvm_pkg::*;

   wr_type               wr;
   result_type           head;
   logic                 accept;
   logic [QCNT_BITS-1:0] level;

   // front: run tracking and labelling, one beat per cycle while full is low
   assign accept = push && !full;

   pvm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .sample  (req_sample),
      .row_end (req_row_end),
      .wr      (wr)
   );

   // back: result queue, takes up to two results in, hands one out
   pvm_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .pop         (pop),
      .empty       (empty),
      .almost_full (full),
      .rd_data     (head),
      .level       (level)
   );

   assign rsp_label            = head.label;
   assign rsp_run_length       = head.run_length;
   assign rsp_length_saturated = head.length_saturated;
   assign rsp_last_of_row      = head.last_of_row;

   // queue never holds more than its depth
   `PVM_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, level <= QCNT_BITS'(QUEUE_DEPTH))
   // nothing waits right after reset
   `PVM_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, empty)
   // the row's final run is never an extremum
   `PVM_ASSERT_NOW(a_last_is_none, clock, reset, !empty && rsp_last_of_row, rsp_label == LABEL_NONE)
   // a row end beat always leaves a result waiting
   `PVM_ASSERT_NEXT(a_row_end_result, clock, reset, accept && req_row_end, !empty)

endmodule

>>> hw/rtl/pvm_front.sv
module pvm_front (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     sample,
   input  logic           row_end,
   output pvm_pkg::wr_type wr
);
   import pvm_pkg::*;

   logic [SAMPLE_BITS-1:0] run_value_ff, run_value_in;
   logic [COUNT_BITS-1:0]  run_count_ff, run_count_in;
   dir_type                entry_dir_ff, entry_dir_in;
   logic                   run_open_ff, run_open_in;
   logic                   overflow_ff, overflow_in;

   logic [SAMPLE_BITS-1:0] s;
   dir_type                dir;
   label_type              close_label;
   result_type             close_res;
   result_type             end_res;
   logic                   close_run;

   assign s   = SAMPLE_BITS'(sample);
   assign dir = (s > run_value_ff) ? DIR_RISE : DIR_FALL;

   always_comb begin
      unique case (entry_dir_ff)
         DIR_RISE: close_label = (dir == DIR_FALL) ? LABEL_PEAK : LABEL_NONE;
         DIR_FALL: close_label = (dir == DIR_RISE) ? LABEL_VALLEY : LABEL_NONE;
         default:  close_label = LABEL_NONE;
      endcase
   end

   always_comb begin
      run_value_in = run_value_ff;
      run_count_in = run_count_ff;
      entry_dir_in = entry_dir_ff;
      run_open_in  = run_open_ff;
      overflow_in  = overflow_ff;
      close_run    = 1'b0;
      priority if (!run_open_ff) begin
         run_value_in = s;
         run_count_in = COUNT_BITS'(1);
         entry_dir_in = DIR_NONE;
         run_open_in  = 1'b1;
         overflow_in  = 1'b0;
      end else if (s == run_value_ff) begin
         if (run_count_ff == '1) begin
            overflow_in = 1'b1;
         end else begin
            run_count_in = run_count_ff + COUNT_BITS'(1);
         end
      end else begin
         close_run    = 1'b1;
         run_value_in = s;
         run_count_in = COUNT_BITS'(1);
         entry_dir_in = dir;
         overflow_in  = 1'b0;
      end

      close_res.label            = close_label;
      close_res.run_length       = 16'(run_count_ff);
      close_res.length_saturated = overflow_ff;
      close_res.last_of_row      = 1'b0;

      // row end closes whatever run is open after this sample
      end_res.label              = LABEL_NONE;
      end_res.run_length         = 16'(run_count_in);
      end_res.length_saturated   = overflow_in;
      end_res.last_of_row        = 1'b1;

      wr.valid0 = accept && (close_run || row_end);
      wr.valid1 = accept && close_run && row_end;
      wr.res0   = close_run ? close_res : end_res;
      wr.res1   = end_res;

      if (row_end) begin
         run_value_in = '0;
         run_count_in = '0;
         entry_dir_in = DIR_NONE;
         run_open_in  = 1'b0;
         overflow_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_count_ff <= '0;
         entry_dir_ff <= DIR_NONE;
         run_open_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
      end else if (accept) begin
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
         entry_dir_ff <= entry_dir_in;
         run_open_ff  <= run_open_in;
         overflow_ff  <= overflow_in;
      end
   end

endmodule

>>> hw/rtl/pvm_queue.sv
module pvm_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  pvm_pkg::wr_type                     wr,
   input  logic                                pop,
   output logic                                empty,
   output logic                                almost_full,
   output pvm_pkg::result_type                 rd_data,
   output logic [$clog2(pvm_pkg::QUEUE_DEPTH+1)-1:0] level
);
   import pvm_pkg::*;

   result_type           mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic [QCNT_BITS-1:0] n_wr;
   logic                 do_pop;

   assign empty       = (count_ff == '0);
   // room for two results is kept so one sample never overruns
   assign almost_full = (count_ff >= QCNT_BITS'(QUEUE_DEPTH - 1));
   assign rd_data     = mem[rd_ptr_ff];
   assign level       = count_ff;
   assign do_pop      = pop && !empty;

   always_comb begin
      n_wr      = QCNT_BITS'(wr.valid0) + QCNT_BITS'(wr.valid1);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(n_wr);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(do_pop);
      count_in  = count_ff + n_wr - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr.valid0) begin
         mem[wr_ptr_ff] <= wr.res0;
      end
      if (wr.valid1) begin
         mem[wr_ptr_ff + PTR_BITS'(1)] <= wr.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
